// File: hw/rtl/pph_pkg.sv
// Package for the PPM header and pixel parser: payload structs, result kinds,
// character codes and saturation limits. Depends on nothing; all RTL files import it.

package pph_pkg;

    // Bits kept for the width and height numbers before saturation.
    localparam int DIM_BITS = 16;
    localparam logic [19:0] DIM_MAX = 20'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [19:0] MAXVAL_MAX = 20'd65535;
    localparam logic [15:0] WIDE_SAMPLE_LIMIT = 16'd256;

    // Entries in the queue between the parser and the output sequencer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Result kinds.
    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_PIXEL     = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
    localparam logic [1:0] KIND_TRUNCATED = 2'd3;

    // Characters the parser looks for.
    localparam logic [7:0] CHAR_P       = 8'h50;
    localparam logic [7:0] CHAR_SIX     = 8'h36;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } byte_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        logic        maxval_too_large;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] pixel_index;
        logic        last_pixel;
    } result_t;

    // One queue entry stands for all results caused by one input byte.
    typedef struct packed {
        logic    has_primary;
        logic    has_trunc;
        result_t primary;
    } entry_t;

endpackage

// File: hw/rtl/ppm_header_and_pixel_parser.sv
// Top level of the binary PPM (P6) header and pixel parser.
// Depends on pph_pkg, pph_front, pph_queue and pph_back.
//
//   Channel   Valid          Stall          Payload                 Moves
//   -------   ------------   ------------   ---------------------   ----------------
//   byte      byte_valid     byte_stall     byte_data   (byte_t)    one file byte
//   result    result_valid   result_stall   result_data (result_t)  one parse result
//
// A byte is taken every cycle while the two-entry queue has room; the parser
// updates its state in the same cycle and writes one queue entry for every
// byte that causes a result. Header, pixel and bad magic requests leave one
// per cycle while result_stall is low; a byte that also truncates the file
// yields a truncation result after its primary. The queue entry of a byte is
// written on accept; loading it into the output register raises result_valid.
// Reset clears the parse state, the queue and the output valid flag at once.
// A stalled result holds in the output register while bytes keep flowing
// until the queue fills, and then byte_stall rises.

module ppm_header_and_pixel_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  pph_pkg::byte_t   byte_data,
    output logic             result_valid,
    input  logic             result_stall,
    output pph_pkg::result_t result_data
);
    import pph_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    entry_t push_entry;
    entry_t q_head;

    // The front end only sees bytes that the queue can absorb.
    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    pph_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (byte_data),
        .push    (push),
        .entry   (push_entry)
    );

    pph_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    pph_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// File: hw/rtl/pph_front.sv
// Parser front end: magic check, number accumulation, comment skipping and
// pixel grouping, one byte per accept. Depends on pph_pkg.

module pph_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  pph_pkg::byte_t byte_in,
    output logic           push,
    output pph_pkg::entry_t entry
);
    import pph_pkg::*;

    localparam logic [2:0] PH_MAGIC1 = 3'd0;
    localparam logic [2:0] PH_MAGIC2 = 3'd1;
    localparam logic [2:0] PH_WIDTH  = 3'd2;
    localparam logic [2:0] PH_HEIGHT = 3'd3;
    localparam logic [2:0] PH_MAXVAL = 3'd4;
    localparam logic [2:0] PH_PIXELS = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_HALT   = 3'd7;

    logic [2:0]  phase_reg, phase_next, phase_cur;
    logic        comment_reg, comment_next, comment_cur;
    logic [15:0] acc_reg, acc_next, acc_cur;
    logic        digits_reg, digits_next, digits_cur;
    logic [15:0] width_reg, width_next, width_cur;
    logic [15:0] height_reg, height_next, height_cur;
    logic [15:0] maxval_reg, maxval_next, maxval_cur;
    logic [31:0] total_reg;
    logic [31:0] count_reg, count_next, count_cur;
    logic [1:0]  chan_reg, chan_next, chan_cur;
    logic [7:0]  red_reg, red_next, red_cur;
    logic [7:0]  green_reg, green_next, green_cur;

    logic [7:0]  c;
    logic        is_digit;
    logic [19:0] acc_wide;
    logic [19:0] lim;
    logic        prim;
    logic [1:0]  prim_kind;
    logic [7:0]  prim_blue;
    logic [31:0] prim_index;
    logic        prim_last;
    logic        trunc;
    logic        empty_image;
    logic        last_px;

    assign c        = byte_in.data_byte;
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign lim      = (phase_cur == PH_MAXVAL) ? MAXVAL_MAX : DIM_MAX;
    assign acc_wide = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
                    + {16'd0, c[3:0]};

    always_comb
    begin
        // A first byte restarts the parse before its own byte is handled.
        phase_cur   = byte_in.first_byte ? PH_MAGIC1 : phase_reg;
        comment_cur = byte_in.first_byte ? 1'b0 : comment_reg;
        acc_cur     = byte_in.first_byte ? 16'd0 : acc_reg;
        digits_cur  = byte_in.first_byte ? 1'b0 : digits_reg;
        width_cur   = byte_in.first_byte ? 16'd0 : width_reg;
        height_cur  = byte_in.first_byte ? 16'd0 : height_reg;
        maxval_cur  = byte_in.first_byte ? 16'd0 : maxval_reg;
        count_cur   = byte_in.first_byte ? 32'd0 : count_reg;
        chan_cur    = byte_in.first_byte ? 2'd0 : chan_reg;
        red_cur     = byte_in.first_byte ? 8'd0 : red_reg;
        green_cur   = byte_in.first_byte ? 8'd0 : green_reg;

        phase_next   = phase_cur;
        comment_next = comment_cur;
        acc_next     = acc_cur;
        digits_next  = digits_cur;
        width_next   = width_cur;
        height_next  = height_cur;
        maxval_next  = maxval_cur;
        count_next   = count_cur;
        chan_next    = chan_cur;
        red_next     = red_cur;
        green_next   = green_cur;

        prim        = 1'b0;
        prim_kind   = KIND_HEADER;
        prim_blue   = 8'd0;
        prim_index  = 32'd0;
        prim_last   = 1'b0;
        empty_image = (width_cur == 16'd0) || (height_cur == 16'd0);
        last_px     = (count_cur + 32'd1) == total_reg;

        unique case (phase_cur)
            PH_MAGIC1, PH_MAGIC2:
            begin
                if (c == ((phase_cur == PH_MAGIC1) ? CHAR_P : CHAR_SIX))
                begin
                    phase_next = phase_cur + 3'd1;
                end
                else
                begin
                    prim       = 1'b1;
                    prim_kind  = KIND_BAD_MAGIC;
                    prim_last  = 1'b1;
                    phase_next = PH_HALT;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
            begin
                if (comment_cur)
                begin
                    if (c == CHAR_NEWLINE)
                    begin
                        comment_next = 1'b0;
                    end
                end
                else if (is_digit)
                begin
                    acc_next    = (acc_wide > lim) ? lim[15:0] : acc_wide[15:0];
                    digits_next = 1'b1;
                end
                else if (!digits_cur)
                begin
                    if (c == CHAR_HASH)
                    begin
                        comment_next = 1'b1;
                    end
                end
                else
                begin
                    acc_next    = 16'd0;
                    digits_next = 1'b0;
                    if (phase_cur == PH_WIDTH)
                    begin
                        width_next = acc_cur;
                    end
                    else if (phase_cur == PH_HEIGHT)
                    begin
                        height_next = acc_cur;
                    end
                    else
                    begin
                        maxval_next = acc_cur;
                    end
                    if (phase_cur == PH_MAXVAL)
                    begin
                        // The separator byte ends the header.
                        prim       = 1'b1;
                        prim_kind  = KIND_HEADER;
                        prim_last  = empty_image;
                        phase_next = empty_image ? PH_DONE : PH_PIXELS;
                        chan_next  = 2'd0;
                        count_next = 32'd0;
                    end
                    else
                    begin
                        if (c == CHAR_HASH)
                        begin
                            comment_next = 1'b1;
                        end
                        phase_next = phase_cur + 3'd1;
                    end
                end
            end
            PH_PIXELS:
            begin
                case (chan_cur)
                    2'd0:
                    begin
                        red_next  = c;
                        chan_next = 2'd1;
                    end
                    2'd1:
                    begin
                        green_next = c;
                        chan_next  = 2'd2;
                    end
                    default:
                    begin
                        prim       = 1'b1;
                        prim_kind  = KIND_PIXEL;
                        prim_blue  = c;
                        prim_index = count_cur;
                        prim_last  = last_px;
                        count_next = count_cur + 32'd1;
                        chan_next  = 2'd0;
                        if (last_px)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        trunc = byte_in.final_byte && (phase_next != PH_DONE) && (phase_next != PH_HALT);
        if (trunc)
        begin
            phase_next = PH_HALT;
        end
    end

    always_comb
    begin
        entry.has_primary              = prim;
        entry.has_trunc                = trunc;
        entry.primary.kind             = prim_kind;
        entry.primary.image_width      = width_next;
        entry.primary.image_height     = height_next;
        entry.primary.max_value        = maxval_next;
        entry.primary.maxval_too_large = maxval_next >= WIDE_SAMPLE_LIMIT;
        entry.primary.red              = (prim_kind == KIND_PIXEL) ? red_cur : 8'd0;
        entry.primary.green            = (prim_kind == KIND_PIXEL) ? green_cur : 8'd0;
        entry.primary.blue             = prim_blue;
        entry.primary.pixel_index      = prim_index;
        entry.primary.last_pixel       = prim_last;
    end

    assign push = accept && (prim || trunc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC1;
            comment_reg <= 1'b0;
            acc_reg     <= 16'd0;
            digits_reg  <= 1'b0;
            width_reg   <= 16'd0;
            height_reg  <= 16'd0;
            maxval_reg  <= 16'd0;
            count_reg   <= 32'd0;
            chan_reg    <= 2'd0;
            red_reg     <= 8'd0;
            green_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            acc_reg     <= acc_next;
            digits_reg  <= digits_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            maxval_reg  <= maxval_next;
            count_reg   <= count_next;
            chan_reg    <= chan_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
        end
    end

    // Height is fixed at least two bytes before the first pixel completes,
    // so a free-running product register is always settled when read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 32'd0;
        end
        else
        begin
            total_reg <= 32'(width_reg) * 32'(height_reg);
        end
    end

endmodule

// File: hw/rtl/pph_queue.sv
// Small register queue carrying per-byte result entries from the parser to
// the output sequencer. Depends on pph_pkg.

module pph_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pph_pkg::entry_t push_entry,
    input  logic            pop,
    output pph_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import pph_pkg::*;

    entry_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign empty   = count_reg == QUEUE_CNT_BITS'(0);
    assign full    = count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QUEUE_CNT_BITS'(1);
            end
        end
    end

endmodule

// File: hw/rtl/pph_back.sv
// Output sequencer: unpacks each queue entry into one or two results and
// holds them in the output register. Depends on pph_pkg.

module pph_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pph_pkg::entry_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output pph_pkg::result_t result_data
);
    import pph_pkg::*;

    logic    valid_reg;
    logic    pending_reg;
    result_t out_reg;
    result_t trunc_res;
    result_t head_res;
    logic    load;

    assign load = !valid_reg || !result_stall;
    assign pop  = load && !pending_reg && !empty;

    // The truncation request repeats the header fields of its own byte.
    always_comb
    begin
        trunc_res             = out_reg;
        trunc_res.kind        = KIND_TRUNCATED;
        trunc_res.red         = 8'd0;
        trunc_res.green       = 8'd0;
        trunc_res.blue        = 8'd0;
        trunc_res.pixel_index = 32'd0;
        trunc_res.last_pixel  = 1'b1;
    end

    // An entry without a primary request carries only the truncation.
    always_comb
    begin
        head_res = head.primary;
        if (!head.has_primary)
        begin
            head_res.kind        = KIND_TRUNCATED;
            head_res.red         = 8'd0;
            head_res.green       = 8'd0;
            head_res.blue        = 8'd0;
            head_res.pixel_index = 32'd0;
            head_res.last_pixel  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pending_reg)
            begin
                out_reg <= trunc_res;
            end
            else if (!empty)
            begin
                out_reg <= head_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (load)
        begin
            if (pending_reg)
            begin
                valid_reg   <= 1'b1;
                pending_reg <= 1'b0;
            end
            else if (!empty)
            begin
                valid_reg   <= 1'b1;
                pending_reg <= head.has_primary && head.has_trunc;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = out_reg;

endmodule
